[rtl/core/rdp_raid6_parity_encoder_core_assert.svh]
// Assertion macros shared by the RDP encoder checkers.
// Expects signals named clk and arst_n in the using scope.
`ifndef RDP_RAID6_PARITY_ENCODER_CORE_ASSERT_SVH
`define RDP_RAID6_PARITY_ENCODER_CORE_ASSERT_SVH

// Single property checked on every clock outside reset.
`define RDP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent this cycle, consequent on the next cycle.
`define RDP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/rdp_pkg.sv]
// Shared types and constants for the RDP RAID-6 parity encoder.
// No dependencies.
package rdp_pkg;

	// Control strobes for one accumulator memory.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clear;
	} mem_ctl_t;

	// Bit n set when n is prime, n = 0..63.
	localparam logic [63:0] PRIME_MASK = 64'h2820_8A20_A08A_28AC;

	function automatic logic is_prime(input logic [5:0] n);
		is_prime = PRIME_MASK[n];
	endfunction

endpackage

[rtl/core/rdp_raid6_parity_encoder_core.sv]
// Top level of the RDP RAID-6 parity encoder: sequencer, two accumulator
// memories and the output register. Uses rdp_pkg and rdp_acc_mem.

// Row-Diagonal Parity encoder for one stripe of w data disks by w rows
// (w = rows_per_stripe, w+1 must be prime, w <= MAX_ROWS). Each input beat
// carries one data word tagged with its disk and row. Row parity P and
// diagonal parity Q live in two single-port-read memories; for a word the
// accept cycle reads P[row] and Q[diag], state S_UPD1 writes them back and
// reads Q[row-1], and S_UPD2 writes the P fold into Q[row-1].
// The sequencer holds s_tready low over that read-modify-write, so no
// entry is read while its update is in flight. A word with a disk or row
// index of w or more, or any word under an invalid configuration, is not
// accumulated. On tlast the block drains P[0..w-1] then Q[0..w-1], each
// result beat being a memory read and then an output register load that
// m_tready can stall; it clears both memories at once via valid bits. With
// an invalid w a single error beat (status set, word zero, tlast) replaces
// the drain. Input is taken while the last result still sits in the output
// register. Write cfg_wdata only when idle.
module rdp_raid6_parity_encoder_core #(
	parameter int MAX_ROWS   = 16,
	parameter int WORD_WIDTH = 64,
	localparam int TDATA_IN_W  = ((8 + WORD_WIDTH + 7) / 8) * 8,
	localparam int TDATA_OUT_W = ((4 + WORD_WIDTH + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration: rows_per_stripe
	input  logic                   cfg_we,
	input  logic [4:0]             cfg_wdata,
	// input beats
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,   // disk_index[3:0], row_index, data_word
	input  logic                   s_tlast,   // last_of_stripe
	// result beats
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,   // parity_row[3:0], parity_word, zero pad
	output logic [1:0]             m_tuser,   // parity_select, status
	output logic                   m_tlast    // last_result
);
	import rdp_pkg::*;

	localparam int AW = $clog2(MAX_ROWS);
	localparam logic [6:0] MAX_ROWS_C = 7'(MAX_ROWS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_UPD1 = 3'd1;  // write P[row], Q[diag]; read Q[row-1]
	localparam logic [2:0] S_UPD2 = 3'd2;  // write Q[row-1]
	localparam logic [2:0] S_DRD  = 3'd3;  // drain: read entry
	localparam logic [2:0] S_DOUT = 3'd4;  // drain: load output register
	localparam logic [2:0] S_ERR  = 3'd5;  // error beat

	logic [2:0] state_q;
	logic [4:0] rows_q;
	logic       sel_q;     // drain phase: 0 P, 1 Q
	logic [4:0] idx_q;     // drain entry

	// config
	logic [5:0] w_plus1;
	logic       cfg_ok;

	assign w_plus1 = {1'b0, rows_q} + 6'd1;
	assign cfg_ok  = is_prime(w_plus1) && ({2'b00, rows_q} <= MAX_ROWS_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 5'd4;
		end else if (cfg_we) begin
			rows_q <= cfg_wdata;
		end
	end

	// input decode
	logic [3:0]            in_disk;
	logic [3:0]            in_row;
	logic [WORD_WIDTH-1:0] in_word;
	logic                  accept;
	logic                  acc_en;
	logic [5:0]            diag_sum;
	logic [5:0]            diag;
	logic [6:0]            row_ext;
	logic [6:0]            diag_ext;
	logic [6:0]            rowm1_ext;
	logic [6:0]            idx_ext;

	assign in_disk = s_tdata[3:0];
	assign in_row  = s_tdata[7:4];
	assign in_word = s_tdata[8 +: WORD_WIDTH];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign acc_en   = cfg_ok && ({1'b0, in_row} < rows_q) && ({1'b0, in_disk} < rows_q);

	// (row + disk) mod (w+1); sum stays below twice the modulus
	assign diag_sum  = {2'b00, in_row} + {2'b00, in_disk};
	assign diag      = (diag_sum >= w_plus1) ? (diag_sum - w_plus1) : diag_sum;
	assign row_ext   = {3'b000, in_row};
	assign diag_ext  = {1'b0, diag};
	assign rowm1_ext = {3'b000, in_row - 4'd1};
	assign idx_ext   = {2'b00, idx_q};

	// stage 1 of the update
	logic [WORD_WIDTH-1:0] word_s1;
	logic [AW-1:0]         row_addr_s1;
	logic [AW-1:0]         diag_addr_s1;
	logic [AW-1:0]         rowm1_addr_s1;
	logic                  diag_hit_s1;
	logic                  row_nz_s1;
	logic                  last_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1       <= in_word;
			row_addr_s1   <= row_ext[AW-1:0];
			diag_addr_s1  <= diag_ext[AW-1:0];
			rowm1_addr_s1 <= rowm1_ext[AW-1:0];
			diag_hit_s1   <= (diag < {1'b0, rows_q});  // missing diagonal skipped
			row_nz_s1     <= (in_row != 4'd0);         // fold of P into Q[row-1]
			last_s1       <= s_tlast;
		end
	end

	// output register
	logic                  out_vld_q;
	logic                  out_sel_q;
	logic [3:0]            out_row_q;
	logic [WORD_WIDTH-1:0] out_word_q;
	logic                  out_last_q;
	logic                  out_stat_q;
	logic                  out_free;
	logic                  idx_last;
	logic                  clr_all;
	logic                  out_load;

	assign out_free = !out_vld_q || m_tready;
	assign idx_last = ((idx_q + 5'd1) == rows_q);
	assign out_load = out_free && ((state_q == S_DOUT) || (state_q == S_ERR));
	assign clr_all  = out_free && (((state_q == S_DOUT) && sel_q && idx_last) ||
		(state_q == S_ERR));

	// memories
	mem_ctl_t              p_ctl;
	mem_ctl_t              q_ctl;
	logic [AW-1:0]         p_raddr;
	logic [AW-1:0]         q_raddr;
	logic [AW-1:0]         q_waddr;
	logic [WORD_WIDTH-1:0] p_rdata;
	logic [WORD_WIDTH-1:0] q_rdata;
	logic [WORD_WIDTH-1:0] p_wdata;
	logic [WORD_WIDTH-1:0] q_wdata;

	always_comb begin
		p_ctl.rd_en = (accept && acc_en) || ((state_q == S_DRD) && !sel_q);
		p_ctl.wr_en = (state_q == S_UPD1);
		p_ctl.clear = clr_all;
		p_raddr     = (state_q == S_DRD) ? idx_ext[AW-1:0] : row_ext[AW-1:0];

		q_ctl.rd_en = (accept && acc_en) || (state_q == S_UPD1) ||
			((state_q == S_DRD) && sel_q);
		q_ctl.wr_en = ((state_q == S_UPD1) && diag_hit_s1) ||
			((state_q == S_UPD2) && row_nz_s1);
		q_ctl.clear = clr_all;
		if (state_q == S_DRD) begin
			q_raddr = idx_ext[AW-1:0];
		end else if (state_q == S_UPD1) begin
			q_raddr = rowm1_addr_s1;
		end else begin
			q_raddr = diag_ext[AW-1:0];
		end
		q_waddr = (state_q == S_UPD2) ? rowm1_addr_s1 : diag_addr_s1;
		p_wdata = p_rdata ^ word_s1;
		q_wdata = q_rdata ^ word_s1;
	end

	rdp_acc_mem #(.DEPTH(MAX_ROWS), .WIDTH(WORD_WIDTH)) u_p_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (p_ctl),
		.raddr  (p_raddr),
		.waddr  (row_addr_s1),
		.wdata  (p_wdata),
		.rdata  (p_rdata)
	);

	rdp_acc_mem #(.DEPTH(MAX_ROWS), .WIDTH(WORD_WIDTH)) u_q_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (q_ctl),
		.raddr  (q_raddr),
		.waddr  (q_waddr),
		.wdata  (q_wdata),
		.rdata  (q_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						sel_q <= 1'b0;
						idx_q <= '0;
						if (acc_en) begin
							state_q <= S_UPD1;
						end else if (s_tlast) begin
							state_q <= cfg_ok ? S_DRD : S_ERR;
						end
					end
				end
				S_UPD1: begin
					state_q <= S_UPD2;
				end
				S_UPD2: begin
					state_q <= last_s1 ? S_DRD : S_IDLE;
				end
				S_DRD: begin
					state_q <= S_DOUT;
				end
				S_DOUT: begin
					if (out_free) begin
						if (idx_last) begin
							idx_q   <= '0;
							sel_q   <= 1'b1;
							state_q <= sel_q ? S_IDLE : S_DRD;
						end else begin
							idx_q   <= idx_q + 5'd1;
							state_q <= S_DRD;
						end
					end
				end
				S_ERR: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == S_ERR) begin
				out_sel_q  <= 1'b0;
				out_row_q  <= '0;
				out_word_q <= '0;
				out_last_q <= 1'b1;
				out_stat_q <= 1'b1;
			end else begin
				out_sel_q  <= sel_q;
				out_row_q  <= idx_q[3:0];
				out_word_q <= sel_q ? q_rdata : p_rdata;
				out_last_q <= sel_q && idx_last;
				out_stat_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_stat_q, out_sel_q};

	always_comb begin
		m_tdata                 = '0;
		m_tdata[3:0]            = out_row_q;
		m_tdata[4 +: WORD_WIDTH] = out_word_q;
	end

endmodule

[rtl/core/rdp_acc_mem.sv]
// Parity accumulator memory: one write port, one registered read port,
// per-entry valid bits so a stripe clear empties all entries. Uses rdp_pkg.
module rdp_acc_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rdp_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]     raddr,
	input  logic [AW-1:0]     waddr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);
	import rdp_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_q;
	logic             rvld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				vld_q <= '0;
			end else if (ctl.wr_en) begin
				vld_q[waddr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	// never-written entries read as zero
	assign rdata = rvld_q ? rdata_q : '0;

endmodule

[rtl/core/rdp_core_chk.sv]
// Port-level checker for the RDP encoder top and its bind.
// Uses the macros in rdp_raid6_parity_encoder_core_assert.svh.
`include "rdp_raid6_parity_encoder_core_assert.svh"

module rdp_core_chk #(
	parameter int TDATA_W = 72
) (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [1:0]         m_tuser,
	input logic               m_tlast
);

	`RDP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")

	`RDP_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result beat changed")

	// error beat stands alone and carries nothing
	`RDP_ASSERT(a_err_beat, (m_tvalid && m_tuser[1]) |-> (m_tlast && !m_tuser[0] && (m_tdata == '0)), "malformed error beat")

	// a good stripe always ends on a diagonal parity word
	`RDP_ASSERT(a_last_is_q, (m_tvalid && m_tlast && !m_tuser[1]) |-> m_tuser[0], "stripe ended on row parity")

endmodule

bind rdp_raid6_parity_encoder_core rdp_core_chk #(.TDATA_W(TDATA_OUT_W)) u_rdp_core_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

[tb/rdp_raid6_parity_encoder_core_test.sv]
// Self-checking testbench for rdp_raid6_parity_encoder_core.
// Holds its own row/diagonal parity model in a small scoreboard class.
// Needs only the RTL of the encoder; no files, no arguments.
`timescale 1ns / 1ps

module rdp_raid6_parity_encoder_core_test;

	localparam int MAX_ROWS        = 16;
	localparam int WORD_WIDTH      = 64;
	localparam int IN_W            = 72;     // disk, row, word
	localparam int OUT_W           = 72;     // row, word, pad
	localparam int CYCLE_LIMIT     = 4000000;
	localparam int HOLD_OFF_CYCLES = 500;    // long receiver stall, fills the block
	localparam int SETTLE_CYCLES   = 8;      // lets the last word's update finish

	// m_tuser codes
	localparam bit SEL_ROW        = 1'b0;    // row parity P
	localparam bit SEL_DIAG       = 1'b1;    // diagonal parity Q
	localparam bit STATUS_OK      = 1'b0;
	localparam bit STATUS_BAD_CFG = 1'b1;    // w+1 not prime or w too large

	typedef struct {
		bit                  sel;
		bit [3:0]            row;
		bit [WORD_WIDTH-1:0] word;
		bit                  last;
		bit                  status;
	} parity_beat_t;

	// Row/diagonal parity predictor plus the queue of parity beats still owed.
	class parity_scoreboard;
		bit [WORD_WIDTH-1:0] row_par [MAX_ROWS];
		bit [WORD_WIDTH-1:0] diag_par [MAX_ROWS];
		bit [4:0]            width;
		parity_beat_t        owed_q [$];
		int                  errors;

		function new();
			width  = 5'd4;
			errors = 0;
			clear_acc();
		endfunction

		function void clear_acc();
			foreach (row_par[i]) begin
				row_par[i]  = '0;
				diag_par[i] = '0;
			end
		endfunction

		function bit width_ok();
			int n;
			int d;
			bit prime;
			n     = width + 1;
			prime = (n >= 2);
			for (d = 2; d * d <= n; d++)
				if (n % d == 0)
					prime = 1'b0;
			return prime && (width <= MAX_ROWS);
		endfunction

		// Fold one accepted data word in; on the stripe's last word queue the parity.
		function void note_word(bit [3:0] disk, bit [3:0] row, bit [WORD_WIDTH-1:0] word,
				bit last);
			bit           ok;
			int           diag;
			int           i;
			parity_beat_t beat;
			ok = width_ok();
			if (ok && row < width && disk < width) begin
				diag = row + disk;
				if (diag >= width + 1)
					diag -= width + 1;
				row_par[row] ^= word;
				if (diag < width)
					diag_par[diag] ^= word;     // diagonal w is the missing one
				if (row >= 1)
					diag_par[row - 1] ^= word;  // P folded into Q
			end
			if (!last)
				return;
			if (!ok) begin
				beat = '{sel: SEL_ROW, row: 4'd0, word: '0, last: 1'b1, status: STATUS_BAD_CFG};
				owed_q.push_back(beat);
			end else begin
				for (i = 0; i < width; i++) begin
					beat = '{sel: SEL_ROW, row: i[3:0], word: row_par[i], last: 1'b0,
						status: STATUS_OK};
					owed_q.push_back(beat);
				end
				for (i = 0; i < width; i++) begin
					beat = '{sel: SEL_DIAG, row: i[3:0], word: diag_par[i],
						last: (i + 1 == width), status: STATUS_OK};
					owed_q.push_back(beat);
				end
			end
			clear_acc();
		endfunction

		function void check_beat(parity_beat_t got);
			parity_beat_t want;
			if (owed_q.size() == 0) begin
				$error("parity beat with nothing owed: row %0d word %h", got.row, got.word);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			if (got.sel != want.sel) begin
				$error("parity_select: expected %0d, got %0d", want.sel, got.sel);
				errors++;
			end
			if (got.row != want.row) begin
				$error("parity_row: expected %0d, got %0d", want.row, got.row);
				errors++;
			end
			if (got.word != want.word) begin
				$error("parity_word: expected %h, got %h", want.word, got.word);
				errors++;
			end
			if (got.last != want.last) begin
				$error("last_result: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
			if (got.status != want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [4:0]       cfg_wdata;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // disk_index[3:0], row_index[7:4], data_word[71:8]
	logic             s_tlast;   // last_of_stripe
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;   // parity_row[3:0], parity_word[67:4], zero pad
	logic [1:0]       m_tuser;   // parity_select[0], status[1]
	logic             m_tlast;   // last_result

	parity_scoreboard parity_sb;
	parity_beat_t     seen_beat;
	bit               hold_off_req = 1'b0;  // stimulus asks receiver for a long stall
	bit               tight_input  = 1'b0;  // back-to-back beats for this stripe
	int               cycle_count;

	rdp_raid6_parity_encoder_core #(
		.MAX_ROWS   (MAX_ROWS),
		.WORD_WIDTH (WORD_WIDTH)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #5 clk = ~clk;

	// Watchdog: the run must end well inside the cycle budget.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("rdp_raid6_parity_encoder_core verification failed");
		$finish;
	end

	// Beat monitor. Values read here are the pre-edge ones, so the accepted
	// beats match what the DUT saw at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				parity_sb.note_word(s_tdata[3:0], s_tdata[7:4], s_tdata[71:8], s_tlast);
			if (m_tvalid && m_tready) begin
				seen_beat.sel    = m_tuser[0];
				seen_beat.status = m_tuser[1];
				seen_beat.row    = m_tdata[3:0];
				seen_beat.word   = m_tdata[67:4];
				seen_beat.last   = m_tlast;
				parity_sb.check_beat(seen_beat);
			end
		end
	end

	// Receiver: ready stretches, short and occasional long stalls, and the one
	// long hold-off on request. Each pass drives m_tready once, then waits.
	initial begin
		int r;
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 20) begin
					m_tready <= 1'b1;                       // stretch with no stalls
					repeat ($urandom_range(20, 60)) @(posedge clk);
				end else if (r < 60) begin
					m_tready <= 1'b1;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end else begin
					r = $urandom_range(0, 99);
					if (r < 80)
						stall = $urandom_range(1, 3);
					else if (r < 96)
						stall = $urandom_range(4, 12);
					else
						stall = $urandom_range(20, 60);
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	// Sender gap before the next beat: mostly none or short, a few long.
	function automatic int pick_gap();
		int r;
		if (tight_input)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Offer one data beat and return at the edge that takes it; tvalid stays
	// high so a following beat can go out with no gap.
	task automatic push_word(bit [3:0] disk, bit [3:0] row, bit [WORD_WIDTH-1:0] word,
			bit last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {word, row, disk};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Called right after a push: drop tvalid, wait for all parity owed,
	// then let the last word's update finish before touching the register.
	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (parity_sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(bit [4:0] w);
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we    <= 1'b0;
		parity_sb.width = w;
	endtask

	// One stripe: either a complete w x w stripe in shuffled order (small w),
	// or a short run of words, mostly in range, ending on tlast.
	task automatic run_stripe(output int sent);
		int       w;
		int       lim;
		int       n;
		int       k;
		int       j;
		bit [7:0] cell_q [$];        // {row, disk}
		bit [7:0] tmp;
		w   = parity_sb.width;
		lim = (w >= 1 && w <= MAX_ROWS) ? w - 1 : 15;
		tight_input = ($urandom_range(0, 3) == 0);
		if (w <= 6 && parity_sb.width_ok() && $urandom_range(0, 2) == 0) begin
			for (k = 0; k < w; k++)
				for (j = 0; j < w; j++)
					cell_q.push_back({k[3:0], j[3:0]});
			for (k = cell_q.size() - 1; k > 0; k--) begin
				j         = $urandom_range(0, k);
				tmp       = cell_q[k];
				cell_q[k] = cell_q[j];
				cell_q[j] = tmp;
			end
		end else begin
			n = $urandom_range(1, 12);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					tmp = 8'($urandom);      // any index, often out of range
				else
					tmp = {4'($urandom_range(0, lim)), 4'($urandom_range(0, lim))};
				cell_q.push_back(tmp);
			end
		end
		foreach (cell_q[i])
			push_word(cell_q[i][3:0], cell_q[i][7:4], {$urandom, $urandom},
				i == cell_q.size() - 1);
		sent = cell_q.size();
		tight_input = 1'b0;
	endtask

	initial begin
		bit [4:0] width_plan [12];
		int budget;
		int phase_items;
		int sent;
		width_plan = '{5'd2, 5'd16, 5'd1, 5'd6, 5'd3, 5'd10, 5'd12,
			5'd0, 5'd31, 5'd17, 5'd22, 5'd4};
		parity_sb = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset width 4 (p = 5).
		push_word(4'd0, 4'd0, '1, 1'b1);                     // lone word stripe
		push_word(4'd3, 4'd3, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0); // diagonal wraps mod p
		push_word(4'd1, 4'd3, 64'h5555_5555_5555_5555, 1'b0); // lands on missing diagonal
		push_word(4'd0, 4'd0, 64'h8000_0000_0000_0001, 1'b0);
		push_word(4'd2, 4'd1, 64'h0, 1'b0);
		push_word(4'd15, 4'd0, '1, 1'b0);                    // disk out of range
		push_word(4'd0, 4'd15, '1, 1'b0);                    // row out of range
		push_word(4'd3, 4'd2, 64'h0123_4567_89AB_CDEF, 1'b0);
		push_word(4'd4, 4'd4, '1, 1'b1);                     // tlast on an ignored word
		push_word(4'd15, 4'd15, '1, 1'b1);                   // stripe of nothing
		drain_and_settle();

		// Directed, invalid width: one error beat, nothing accumulated.
		write_width(5'd3);
		push_word(4'd1, 4'd1, '1, 1'b0);
		push_word(4'd2, 4'd0, 64'hDEAD_BEEF_0000_FFFF, 1'b1);
		drain_and_settle();

		// Random phases over valid, boundary and invalid widths.
		foreach (width_plan[p]) begin
			write_width(width_plan[p]);
			budget      = parity_sb.width_ok() ? 30 : 12;
			phase_items = 0;
			if (width_plan[p] == 5'd16)
				hold_off_req = 1'b1;     // back up the 32-beat drain, stall the input
			while (phase_items < budget) begin
				run_stripe(sent);
				phase_items += sent;
			end
			drain_and_settle();
		end

		repeat (20) @(posedge clk);
		if (parity_sb.errors == 0)
			$display("rdp_raid6_parity_encoder_core verification clean");
		else
			$display("rdp_raid6_parity_encoder_core verification failed");
		$finish;
	end

endmodule
